/* src/hsfc_pkg.sv */
// shared types, constants and arithmetic helpers of the humidity sensor frame checker
`default_nettype none
package hsfc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam int unsigned TEMP_SPAN   = 17500;
	localparam int unsigned HUM_SPAN    = 10000;
	localparam int unsigned TEMP_OFFSET = 4500;
	localparam int unsigned FULL_SCALE  = 65535;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned PROD_W = 31;
	localparam int unsigned QUOT_W = 15;

	typedef struct packed {
		logic        status;
		logic [15:0] temperature_word;
		logic [15:0] humidity_word;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(x / 65535) for x below 2^31: estimate by the high half, one correction step
	function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
		logic [QUOT_W-1:0] q_est;
		logic [16:0]       rem;
		q_est = x[PROD_W-1:16];
		rem   = {1'b0, x[15:0]} + 17'(q_est);
		if (rem >= 17'(FULL_SCALE)) begin
			return q_est + QUOT_W'(1);
		end else begin
			return q_est;
		end
	endfunction

endpackage
`default_nettype wire

/* src/hsfc_front.sv */
// front end: byte position tracking, word assembly and crc check per frame
`default_nettype none
module hsfc_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      byte_accept,
	input  wire [7:0]                frame_byte,
	input  wire                      frame_start,
	output logic                     rec_push,
	output hsfc_pkg::frame_rec_t     rec
);
	import hsfc_pkg::*;

	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] t_hold_q;
	logic [15:0] h_hold_q;
	logic        mism_q;
	logic [2:0]  pos_eff;
	logic [7:0]  crc_in;
	logic [7:0]  crc_next;

	// a start flag or an impossible position restarts the frame
	assign pos_eff  = (frame_start || pos_q > POS_H_CRC) ? POS_T_HI : pos_q;
	assign crc_in   = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_q;
	assign crc_next = crc_byte(crc_in, frame_byte);

	assign rec_push             = byte_accept && (pos_eff == POS_H_CRC);
	assign rec.status           = mism_q || (crc_q != frame_byte);
	assign rec.temperature_word = t_hold_q;
	assign rec.humidity_word    = h_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_T_HI;
			crc_q    <= CRC_INIT;
			t_hold_q <= '0;
			h_hold_q <= '0;
			mism_q   <= 1'b0;
		end else if (byte_accept) begin
			case (pos_eff)
				POS_T_HI: begin
					mism_q   <= 1'b0;
					crc_q    <= crc_next;
					t_hold_q <= {frame_byte, 8'h00};
					pos_q    <= POS_T_LO;
				end
				POS_T_LO: begin
					crc_q         <= crc_next;
					t_hold_q[7:0] <= frame_byte;
					pos_q         <= POS_T_CRC;
				end
				POS_T_CRC: begin
					mism_q <= (crc_q != frame_byte);
					crc_q  <= CRC_INIT;
					pos_q  <= POS_H_HI;
				end
				POS_H_HI: begin
					crc_q    <= crc_next;
					h_hold_q <= {frame_byte, 8'h00};
					pos_q    <= POS_H_LO;
				end
				POS_H_LO: begin
					crc_q         <= crc_next;
					h_hold_q[7:0] <= frame_byte;
					pos_q         <= POS_H_CRC;
				end
				default: begin
					mism_q <= 1'b0;
					crc_q  <= CRC_INIT;
					pos_q  <= POS_T_HI;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/hsfc_queue.sv */
// small register queue of checked frames between front and back end
`default_nettype none
module hsfc_queue #(
	parameter int unsigned DEPTH = hsfc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      wr_en,
	input  hsfc_pkg::frame_rec_t     wr_rec,
	input  wire                      rd_en,
	output hsfc_pkg::frame_rec_t     rd_rec,
	output hsfc_pkg::queue_stat_t    stat
);
	import hsfc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	frame_rec_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* src/hsfc_back.sv */
// back end: two-stage scaling pipeline, product then divide-by-full-scale and offset
`default_nettype none
module hsfc_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  hsfc_pkg::queue_stat_t    q_stat,
	input  hsfc_pkg::frame_rec_t     q_rec,
	output logic                     q_pop,
	input  wire                      pop,
	output logic                     empty,
	output logic                     status,
	output logic signed [14:0]       temperature_centi,
	output logic [13:0]              humidity_centi,
	output logic [15:0]              temperature_word,
	output logic [15:0]              humidity_word
);
	import hsfc_pkg::*;

	logic              valid_s1;
	logic              status_s1;
	logic [15:0]       t_word_s1;
	logic [15:0]       h_word_s1;
	logic [PROD_W-1:0] t_prod_s1;
	logic [PROD_W-1:0] h_prod_s1;

	logic              valid_s2;
	logic              status_s2;
	logic [14:0]       t_centi_s2;
	logic [13:0]       h_centi_s2;
	logic [15:0]       t_word_s2;
	logic [15:0]       h_word_s2;

	logic              s2_ready;
	logic              s1_ready;
	logic [QUOT_W-1:0] t_scaled;
	logic [QUOT_W-1:0] h_scaled;

	assign s2_ready = !valid_s2 || pop;
	assign s1_ready = !valid_s1 || s2_ready;
	assign q_pop    = !q_stat.empty && s1_ready;

	assign t_scaled = div_full_scale(t_prod_s1);
	assign h_scaled = div_full_scale(h_prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= !q_stat.empty;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_s1 <= q_rec.status;
			t_word_s1 <= q_rec.temperature_word;
			h_word_s1 <= q_rec.humidity_word;
			t_prod_s1 <= PROD_W'(q_rec.temperature_word) * PROD_W'(TEMP_SPAN);
			h_prod_s1 <= PROD_W'(q_rec.humidity_word) * PROD_W'(HUM_SPAN);
		end
		if (s2_ready && valid_s1) begin
			status_s2  <= status_s1;
			t_word_s2  <= t_word_s1;
			h_word_s2  <= h_word_s1;
			// two's complement wrap gives the signed result in 15 bits
			t_centi_s2 <= t_scaled - 15'(TEMP_OFFSET);
			h_centi_s2 <= h_scaled[13:0];
		end
	end

	assign empty             = !valid_s2;
	assign status            = status_s2;
	assign temperature_centi = $signed(t_centi_s2);
	assign humidity_centi    = h_centi_s2;
	assign temperature_word  = t_word_s2;
	assign humidity_word     = h_word_s2;

endmodule
`default_nettype wire

/* src/humidity_sensor_frame_checker.sv */
// top level of the humidity sensor frame checker
//
// channel   handshake          payload
// input     push / full        frame_byte, frame_start
// result    empty / pop        status, temperature_centi, humidity_centi,
//                              temperature_word, humidity_word
//
// one byte per cycle in while full is low; one result per six bytes: the sixth byte's
// request pushes a checked frame into the queue, and the result then passes the multiply
// and divide stages before it shows on the result outputs, where pop can take it.
// the byte-wide crc is one step per accepted byte in the front end; scaling is a multiply stage
// followed by a divide-correct stage in the back end.
// reset clears the byte position, crc, queue and pipeline valids; no clearing pass.
// full rises only when the frame queue is full, so a stalled result holds the front
// off after QUEUE_DEPTH frames plus the two pipeline stages.
`default_nettype none
module humidity_sensor_frame_checker #(
	parameter int unsigned QUEUE_DEPTH = hsfc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire [7:0]          frame_byte,
	input  wire                frame_start,
	output logic               empty,
	input  wire                pop,
	output logic               status,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic [15:0]        temperature_word,
	output logic [15:0]        humidity_word
);
	import hsfc_pkg::*;

	logic        byte_accept;
	logic        rec_push;
	frame_rec_t  front_rec;
	frame_rec_t  q_rec;
	queue_stat_t q_stat;
	logic        q_pop;

	assign full        = q_stat.full;
	assign byte_accept = push && !full;

	hsfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_accept (byte_accept),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.rec_push    (rec_push),
		.rec         (front_rec)
	);

	hsfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_push),
		.wr_rec (front_rec),
		.rd_en  (q_pop),
		.rd_rec (q_rec),
		.stat   (q_stat)
	);

	hsfc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.q_rec             (q_rec),
		.q_pop             (q_pop),
		.pop               (pop),
		.empty             (empty),
		.status            (status),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.temperature_word  (temperature_word),
		.humidity_word     (humidity_word)
	);

	a_queue_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("frame queue reports full and empty together");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000))
		else $error("scaled temperature out of range");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> humidity_centi <= 14'd10000)
		else $error("scaled humidity out of range");

	a_hum_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && humidity_word == 16'hFFFF) |-> humidity_centi == 14'd10000)
		else $error("full scale humidity word not scaled to 100 percent");

endmodule
`default_nettype wire

/* bench/humidity_sensor_frame_checker_tb.sv */
// testbench for the humidity sensor frame checker: random frames, crc prediction, scaled checks
`timescale 1ns / 1ps
module humidity_sensor_frame_checker_tb;
	import hsfc_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 10;
	localparam int PHASE_ITEMS = 542;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} byte_req_t;

	typedef struct {
		logic               status;
		logic signed [14:0] t_centi;
		logic [13:0]        h_centi;
		logic [15:0]        t_word;
		logic [15:0]        h_word;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic [7:0]         frame_byte = 8'h00;
	logic               frame_start = 1'b0;
	logic               pop = 1'b0;
	logic               full;
	logic               empty;
	logic               status;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;
	logic [15:0]        temperature_word;
	logic [15:0]        humidity_word;

	byte_req_t bytes_pending[$];
	reading_t  readings_due[$];

	// frame decoder state, mirrors the block
	logic [2:0]  frame_pos = 3'd0;
	logic [7:0]  crc_acc = CRC_INIT;
	logic [15:0] temp_acc = 16'h0000;
	logic [15:0] hum_acc = 16'h0000;
	logic        temp_crc_bad = 1'b0;

	int send_idle = 31;
	int recv_idle = 78;
	int errors = 0;
	int readings_checked = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet = 0;
	bit aligned = 1'b1;

	humidity_sensor_frame_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.frame_byte(frame_byte),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.status(status),
		.temperature_centi(temperature_centi),
		.humidity_centi(humidity_centi),
		.temperature_word(temperature_word),
		.humidity_word(humidity_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] crc8_word(input logic [15:0] w);
		return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	task automatic frame_decode(input logic [7:0] b, input logic s);
		logic [2:0]  pos;
		reading_t    r;
		int unsigned scaled;
		pos = (s || frame_pos > 3'd5) ? 3'd0 : frame_pos;
		case (pos)
			3'd0: begin
				temp_crc_bad = 1'b0;
				crc_acc = crc8_step(CRC_INIT, b);
				temp_acc = {b, 8'h00};
				frame_pos = 3'd1;
			end
			3'd1: begin
				crc_acc = crc8_step(crc_acc, b);
				temp_acc[7:0] = b;
				frame_pos = 3'd2;
			end
			3'd2: begin
				temp_crc_bad = (crc_acc != b);
				crc_acc = CRC_INIT;
				frame_pos = 3'd3;
			end
			3'd3: begin
				crc_acc = crc8_step(CRC_INIT, b);
				hum_acc = {b, 8'h00};
				frame_pos = 3'd4;
			end
			3'd4: begin
				crc_acc = crc8_step(crc_acc, b);
				hum_acc[7:0] = b;
				frame_pos = 3'd5;
			end
			default: begin
				r.status = temp_crc_bad | (crc_acc != b);
				scaled = (TEMP_SPAN * temp_acc) / FULL_SCALE;
				r.t_centi = 15'(int'(scaled) - int'(TEMP_OFFSET));
				scaled = (HUM_SPAN * hum_acc) / FULL_SCALE;
				r.h_centi = 14'(scaled);
				r.t_word = temp_acc;
				r.h_word = hum_acc;
				readings_due.push_back(r);
				frame_pos = 3'd0;
				crc_acc = CRC_INIT;
				temp_crc_bad = 1'b0;
			end
		endcase
	endtask

	task automatic add_frame(input logic [15:0] tw, input logic [15:0] hw,
			input logic bad_t, input logic bad_h, input logic s);
		logic [7:0] tc;
		logic [7:0] hc;
		tc = crc8_word(tw) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
		hc = crc8_word(hw) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
		bytes_pending.push_back('{tw[15:8], s});
		bytes_pending.push_back('{tw[7:0], 1'b0});
		bytes_pending.push_back('{tc, 1'b0});
		bytes_pending.push_back('{hw[15:8], 1'b0});
		bytes_pending.push_back('{hw[7:0], 1'b0});
		bytes_pending.push_back('{hc, 1'b0});
	endtask

	function automatic logic [15:0] pick_word();
		logic [15:0] corners[5];
		corners = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000};
		if ($urandom_range(99) < 10) begin
			return corners[$urandom_range(4)];
		end
		return 16'($urandom);
	endfunction

	// mostly well-formed frames, some cut short and some raw byte noise
	task automatic add_random(input int count);
		int target;
		int roll;
		int n;
		target = bytes_pending.size() + count;
		while (bytes_pending.size() < target) begin
			roll = $urandom_range(99);
			if (roll < 80) begin
				add_frame(pick_word(), pick_word(), $urandom_range(99) < 15,
					$urandom_range(99) < 15, !aligned || $urandom_range(99) < 70);
				aligned = 1'b1;
			end else if (roll < 92) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					bytes_pending.push_back('{8'($urandom), i == 0});
				end
				aligned = 1'b0;
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					bytes_pending.push_back('{8'($urandom), $urandom_range(99) < 25});
				end
				aligned = 1'b0;
			end
		end
	endtask

	task automatic wait_drained();
		while (bytes_pending.size() != 0 || push || readings_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin : driver
		byte_req_t nxt;
		if (arst_n) begin
			if (push && !full) begin
				frame_decode(frame_byte, frame_start);
			end
			if (!push || !full) begin
				if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
					nxt = bytes_pending.pop_front();
					push <= 1'b1;
					frame_byte <= nxt.data;
					frame_start <= nxt.start;
				end else begin
					// idle cycles carry junk on the payload
					push <= 1'b0;
					frame_byte <= 8'($urandom);
					frame_start <= 1'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		reading_t want;
		logic     nxt_pop;
		if (arst_n && pop && !empty) begin
			if (readings_due.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected reading: status %0b temp %0d hum %0d words %h %h",
						status, temperature_centi, humidity_centi,
						temperature_word, humidity_word);
				end
			end else begin
				want = readings_due.pop_front();
				readings_checked++;
				if (status !== want.status || temperature_centi !== want.t_centi ||
						humidity_centi !== want.h_centi || temperature_word !== want.t_word ||
						humidity_word !== want.h_word) begin
					errors++;
					if (errors <= 10) begin
						$display("reading %0d mismatch: expected %0b %0d %0d %h %h, got %0b %0d %0d %h %h",
							readings_checked, want.status, want.t_centi, want.h_centi,
							want.t_word, want.h_word, status, temperature_centi,
							humidity_centi, temperature_word, humidity_word);
					end
				end
			end
			if (readings_checked == 40 && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
		end
		// long hold-off lets the block back up and raise full
		if (hold_left > 0) begin
			hold_left--;
			nxt_pop = 1'b0;
		end else begin
			nxt_pop = ($urandom_range(99) >= recv_idle);
		end
		pop <= nxt_pop;
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("humidity_sensor_frame_checker verification failed");
				$finish;
			end
		end
	end

	initial begin
		// extremes, wrap without start, start mid-frame, bad crc in each word
		add_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
		add_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		bytes_pending.push_back('{8'hA5, 1'b1});
		bytes_pending.push_back('{8'h5A, 1'b0});
		add_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
		add_frame(16'h8000, 16'h0001, 1'b0, 1'b1, 1'b1);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		add_random(PHASE_ITEMS);
		while (bytes_pending.size() != 0) @(posedge clk);
		send_idle = 78;
		recv_idle = 31;
		wait_drained();

		add_random(PHASE_ITEMS);
		while (bytes_pending.size() != 0) @(posedge clk);
		send_idle = 0;
		recv_idle = 0;
		add_random(PHASE_ITEMS);
		wait_drained();

		if (errors == 0) begin
			$display("humidity_sensor_frame_checker verification clean");
		end else begin
			$display("humidity_sensor_frame_checker verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
src/hsfc_pkg.sv
src/hsfc_front.sv
src/hsfc_queue.sv
src/hsfc_back.sv
src/humidity_sensor_frame_checker.sv
bench/humidity_sensor_frame_checker_tb.sv
